/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDZ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sdz_pkg.sv */
// ----------------------------------------------------------------------------
// sdz_pkg
// types and constants shared by the stick dead zone controller and datapath
// ----------------------------------------------------------------------------
package sdz_pkg;

	// fixed point widths
	localparam int unsigned DZ_W    = 14;
	localparam int unsigned RAW_W   = 8;
	localparam int unsigned OUT_W   = 16;
	localparam int unsigned MUL_W   = 15;
	localparam int unsigned PROD_W  = 30;
	localparam int unsigned DEN_W   = 29;
	localparam int unsigned QUO_W   = 17;

	// dead zone reset, about 0.16 of full scale
	localparam logic [DZ_W-1:0] DZ_RESET = 14'd2621;
	// one in Q1.14, held in a multiplier operand
	localparam logic [MUL_W-1:0] Q14_ONE = 15'd16384;

	// last step index of the root and divide counters
	localparam logic [4:0] SQRT_LAST = 5'd14;
	localparam logic [4:0] DIV_LAST  = 5'd16;

	// configuration register indexes
	localparam logic CFG_LEFT_DZ  = 1'b0;
	localparam logic CFG_RIGHT_DZ = 1'b1;

	// event kinds
	typedef enum logic [1:0] {
		ACT_MOVE = 2'd0,
		ACT_DOWN = 2'd1,
		ACT_UP   = 2'd2
	} action_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_DZSQ,
		ST_TEST,
		ST_SQRT,
		ST_DEN,
		ST_MULA,
		ST_DIVI,
		ST_DIV,
		ST_SAT,
		ST_DONE
	} state_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_DZSQ,
		OP_TEST,
		OP_SQRT,
		OP_DEN,
		OP_MULA,
		OP_DIVI,
		OP_DIV,
		OP_SAT,
		OP_OUT
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t     op;
		logic       axis;
		logic [3:0] step;
	} sdz_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;
	} sdz_status_t;

endpackage

/* rtl/stick_radial_deadzone_events_core.sv */
// ----------------------------------------------------------------------------
// stick_radial_deadzone_events_core
// radial dead zone and down/move/up events for two analog sticks
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one 8-bit X/Y sample and the
//   stick it belongs to. Output channel (out_valid/out_ready) carries one
//   transaction per sample: the stick, both axes in signed Q2.14 after the
//   dead zone, and the event kind.
//   Config channel (cfg_valid/cfg_ready) writes the dead zone radius of
//   the left (index 0) or right (index 1) stick; it is always ready. The user
//   must write it only while no sample is in flight; the block does not enforce it.
//   A sample inside the dead zone or at center skips the root and the
//   divides; any other sample goes through the 15-step square root and
//   two 17-step restoring divides on one shared datapath. One sample is
//   worked on at a time: the next is accepted only after the last has
//   gone to the output register.
//   A finished result waits in its output register; the next sample is
//   accepted meanwhile and only its own completion waits for out_ready.
//   Reset sets both radii to 2621 (about 0.16) and marks every stick as
//   resting, so the first sample outside the dead zone gives DOWN.
// ----------------------------------------------------------------------------

module stick_radial_deadzone_events_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               stick,
	input  logic [7:0]         raw_horizontal,
	input  logic [7:0]         raw_vertical,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               stick_tag,
	output logic signed [15:0] conditioned_horizontal,
	output logic signed [15:0] conditioned_vertical,
	output logic [1:0]         action,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [13:0]        cfg_data
);

	sdz_pkg::sdz_cmd_t    cmd;
	sdz_pkg::sdz_status_t status;

	// configuration is taken at any time
	assign cfg_ready = 1'b1;

	// sequencer
	sdz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	sdz_datapath u_datapath (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.status                 (status),
		.cfg_we                 (cfg_valid & cfg_ready),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.stick                  (stick),
		.raw_horizontal         (raw_horizontal),
		.raw_vertical           (raw_vertical),
		.stick_tag              (stick_tag),
		.conditioned_horizontal (conditioned_horizontal),
		.conditioned_vertical   (conditioned_vertical),
		.action                 (action)
	);

endmodule

/* rtl/sdz_ctrl.sv */
// ----------------------------------------------------------------------------
// sdz_ctrl
// sequencer for one stick sample: squares, dead zone test, root, two divides
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdz_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sdz_pkg::sdz_status_t status,
	output sdz_pkg::sdz_cmd_t    cmd
);

	sdz_pkg::state_t state_q, state_d;
	logic [4:0]      cnt_q, cnt_d;
	logic            axis_q, axis_d;
	logic            out_valid_q;

	// state, counter and axis registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdz_pkg::ST_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			if (cmd.op == sdz_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		axis_d   = axis_q;
		cmd.op   = sdz_pkg::OP_NONE;
		cmd.axis = axis_q;
		cmd.step = cnt_q[3:0];
		case (state_q)
			sdz_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = sdz_pkg::OP_LOAD;
					state_d = sdz_pkg::ST_SQX;
				end
			end
			sdz_pkg::ST_SQX: begin
				cmd.op  = sdz_pkg::OP_SQX;
				state_d = sdz_pkg::ST_SQY;
			end
			sdz_pkg::ST_SQY: begin
				cmd.op  = sdz_pkg::OP_SQY;
				state_d = sdz_pkg::ST_DZSQ;
			end
			sdz_pkg::ST_DZSQ: begin
				cmd.op  = sdz_pkg::OP_DZSQ;
				state_d = sdz_pkg::ST_TEST;
			end
			sdz_pkg::ST_TEST: begin
				cmd.op = sdz_pkg::OP_TEST;
				cnt_d  = sdz_pkg::SQRT_LAST;
				state_d = status.skip ? sdz_pkg::ST_DONE : sdz_pkg::ST_SQRT;
			end
			sdz_pkg::ST_SQRT: begin
				cmd.op = sdz_pkg::OP_SQRT;
				if (cnt_q == '0) begin
					state_d = sdz_pkg::ST_DEN;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			sdz_pkg::ST_DEN: begin
				cmd.op  = sdz_pkg::OP_DEN;
				axis_d  = 1'b0;
				state_d = sdz_pkg::ST_MULA;
			end
			sdz_pkg::ST_MULA: begin
				cmd.op  = sdz_pkg::OP_MULA;
				state_d = sdz_pkg::ST_DIVI;
			end
			sdz_pkg::ST_DIVI: begin
				cmd.op  = sdz_pkg::OP_DIVI;
				cnt_d   = sdz_pkg::DIV_LAST;
				state_d = sdz_pkg::ST_DIV;
			end
			sdz_pkg::ST_DIV: begin
				cmd.op = sdz_pkg::OP_DIV;
				if (cnt_q == '0) begin
					state_d = sdz_pkg::ST_SAT;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			sdz_pkg::ST_SAT: begin
				cmd.op = sdz_pkg::OP_SAT;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = sdz_pkg::ST_MULA;
				end else begin
					state_d = sdz_pkg::ST_DONE;
				end
			end
			sdz_pkg::ST_DONE: begin
				// result register free or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.op  = sdz_pkg::OP_OUT;
					state_d = sdz_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdz_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == sdz_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// a new result only ever comes out of the done state
	`SDZ_ASSERT_NOW(a_rose_from_done, $rose(out_valid_q),
		$past(state_q) == sdz_pkg::ST_DONE, "result raised outside done state")
	// an unconsumed result is never overwritten
	`SDZ_ASSERT_NOW(a_no_overwrite, cmd.op == sdz_pkg::OP_OUT,
		!out_valid_q || out_ready, "result register overwritten while full")
	// divide starts with its full step count after its setup
	`SDZ_ASSERT_NEXT(a_div_len, state_q == sdz_pkg::ST_DIVI,
		state_q == sdz_pkg::ST_DIV && cnt_q == sdz_pkg::DIV_LAST, "divide not started")

endmodule

/* rtl/sdz_datapath.sv */
// ----------------------------------------------------------------------------
// sdz_datapath
// dead zone registers, shared multiplier, root and divide units, event history
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdz_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdz_pkg::sdz_cmd_t    cmd,
	output sdz_pkg::sdz_status_t status,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [13:0]          cfg_data,
	input  logic                 stick,
	input  logic [7:0]           raw_horizontal,
	input  logic [7:0]           raw_vertical,
	output logic                 stick_tag,
	output logic signed [15:0]   conditioned_horizontal,
	output logic signed [15:0]   conditioned_vertical,
	output logic [1:0]           action
);

	// configuration and history
	logic [sdz_pkg::DZ_W-1:0] left_dz_q, right_dz_q;
	logic [1:0]               prev_zero_q, old_zero_q;

	// sample registers
	logic                     stick_q;
	logic [7:0]               xmag_q, ymag_q;
	logic                     xneg_q, yneg_q;
	logic [sdz_pkg::DZ_W-1:0] dz_q;

	// arithmetic registers
	logic [sdz_pkg::PROD_W-1:0] prod_q;
	logic [15:0]                m2_q;
	logic [sdz_pkg::PROD_W-1:0] rad_q, root_q;
	logic [sdz_pkg::DEN_W-1:0]  den_q, rem_q;
	logic [sdz_pkg::QUO_W-1:0]  low_q, quo_q;
	logic                       ovf_q;
	logic signed [15:0]         qx_q, qy_q;

	// result registers
	logic                       tag_q;
	logic signed [15:0]         outx_q, outy_q;
	sdz_pkg::action_t           action_q;

	// combinational terms
	logic [sdz_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [sdz_pkg::PROD_W-1:0] mul_p;
	logic [sdz_pkg::PROD_W-1:0] m2_shift;
	logic [sdz_pkg::MUL_W-1:0]  mag;
	logic [7:0]                 amag;
	logic                       aneg;
	logic [sdz_pkg::PROD_W-1:0] sq_bit, sq_trial;
	logic [43:0]                num_full;
	logic [26:0]                num_hi;
	logic [sdz_pkg::PROD_W-1:0] div_sh;
	logic signed [15:0]         sat_val;
	logic                       cur_zero, prev_zero, old_zero;
	sdz_pkg::action_t           act_d;

	assign m2_shift = {m2_q, 14'b0};
	assign mag      = root_q[sdz_pkg::MUL_W-1:0];
	assign amag     = cmd.axis ? ymag_q : xmag_q;
	assign aneg     = cmd.axis ? yneg_q : xneg_q;

	// sample falls in the dead zone, or sits at center
	assign status.skip = (m2_shift < prod_q) || (m2_q == '0);

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			sdz_pkg::OP_SQX: begin
				mul_a = {7'b0, xmag_q};
				mul_b = {7'b0, xmag_q};
			end
			sdz_pkg::OP_SQY: begin
				mul_a = {7'b0, ymag_q};
				mul_b = {7'b0, ymag_q};
			end
			sdz_pkg::OP_DZSQ: begin
				mul_a = {1'b0, dz_q};
				mul_b = {1'b0, dz_q};
			end
			sdz_pkg::OP_DEN: begin
				mul_a = mag;
				mul_b = sdz_pkg::Q14_ONE - {1'b0, dz_q};
			end
			sdz_pkg::OP_MULA: begin
				mul_a = {amag, 7'b0};
				mul_b = mag - {1'b0, dz_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// root step, one result bit per cycle
	assign sq_bit   = sdz_pkg::PROD_W'(1) << {cmd.step, 1'b0};
	assign sq_trial = root_q + sq_bit;

	// rounded numerator and the part above the quotient bits
	assign num_full = {1'b0, prod_q[sdz_pkg::DEN_W-1:0], 14'b0} + {16'b0, den_q[28:1]};
	assign num_hi   = num_full[43:17];

	// restoring divide step
	assign div_sh = {rem_q, low_q[sdz_pkg::QUO_W-1]};

	// saturate the quotient with the axis sign
	always_comb begin
		if (aneg) begin
			if (ovf_q || quo_q > 17'd32768) begin
				sat_val = 16'sh8000;
			end else begin
				sat_val = signed'(16'(17'd0 - quo_q));
			end
		end else begin
			if (ovf_q || quo_q > 17'd32767) begin
				sat_val = 16'sh7FFF;
			end else begin
				sat_val = signed'(quo_q[15:0]);
			end
		end
	end

	// event kind from the per-stick zero history
	assign cur_zero  = (qx_q == '0) && (qy_q == '0);
	assign prev_zero = prev_zero_q[stick_q];
	assign old_zero  = old_zero_q[stick_q];

	always_comb begin
		if (cur_zero && prev_zero && !old_zero) begin
			act_d = sdz_pkg::ACT_UP;
		end else if (!cur_zero && prev_zero && old_zero) begin
			act_d = sdz_pkg::ACT_DOWN;
		end else begin
			act_d = sdz_pkg::ACT_MOVE;
		end
	end

	// configuration and history registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q   <= sdz_pkg::DZ_RESET;
			right_dz_q  <= sdz_pkg::DZ_RESET;
			prev_zero_q <= 2'b11;
			old_zero_q  <= 2'b11;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sdz_pkg::CFG_LEFT_DZ:  left_dz_q  <= cfg_data;
					sdz_pkg::CFG_RIGHT_DZ: right_dz_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == sdz_pkg::OP_OUT) begin
				old_zero_q[stick_q]  <= prev_zero;
				prev_zero_q[stick_q] <= cur_zero;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			sdz_pkg::OP_LOAD: begin
				stick_q <= stick;
				xneg_q  <= ~raw_horizontal[7];
				yneg_q  <= ~raw_vertical[7];
				xmag_q  <= raw_horizontal[7] ? {1'b0, raw_horizontal[6:0]}
					: 8'(8'h80 - raw_horizontal);
				ymag_q  <= raw_vertical[7] ? {1'b0, raw_vertical[6:0]}
					: 8'(8'h80 - raw_vertical);
				dz_q    <= stick ? right_dz_q : left_dz_q;
			end
			sdz_pkg::OP_SQX: begin
				prod_q <= mul_p;
			end
			sdz_pkg::OP_SQY: begin
				m2_q   <= prod_q[15:0];
				prod_q <= mul_p;
			end
			sdz_pkg::OP_DZSQ: begin
				m2_q   <= m2_q + prod_q[15:0];
				prod_q <= mul_p;
			end
			sdz_pkg::OP_TEST: begin
				rad_q  <= m2_shift;
				root_q <= '0;
				qx_q   <= '0;
				qy_q   <= '0;
			end
			sdz_pkg::OP_SQRT: begin
				if (rad_q >= sq_trial) begin
					rad_q  <= rad_q - sq_trial;
					root_q <= (root_q >> 1) + sq_bit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			sdz_pkg::OP_DEN: begin
				prod_q <= mul_p;
			end
			sdz_pkg::OP_MULA: begin
				// divisor is shared by both axes
				if (!cmd.axis) begin
					den_q <= prod_q[sdz_pkg::DEN_W-1:0];
				end
				prod_q <= mul_p;
			end
			sdz_pkg::OP_DIVI: begin
				rem_q <= {2'b0, num_hi};
				low_q <= num_full[16:0];
				ovf_q <= {2'b0, num_hi} >= den_q;
				quo_q <= '0;
			end
			sdz_pkg::OP_DIV: begin
				if (div_sh >= {1'b0, den_q}) begin
					rem_q <= sdz_pkg::DEN_W'(div_sh - {1'b0, den_q});
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= div_sh[sdz_pkg::DEN_W-1:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
				low_q <= {low_q[15:0], 1'b0};
			end
			sdz_pkg::OP_SAT: begin
				if (cmd.axis) begin
					qy_q <= sat_val;
				end else begin
					qx_q <= sat_val;
				end
			end
			sdz_pkg::OP_OUT: begin
				tag_q    <= stick_q;
				outx_q   <= qx_q;
				outy_q   <= qy_q;
				action_q <= act_d;
			end
			default: ;
		endcase
	end

	assign stick_tag              = tag_q;
	assign conditioned_horizontal = outx_q;
	assign conditioned_vertical   = outy_q;
	assign action                 = action_q;

	// magnitude fits its operand once the root is done
	`SDZ_ASSERT_NOW(a_root_fits, cmd.op == sdz_pkg::OP_DEN,
		root_q[sdz_pkg::PROD_W-1:sdz_pkg::MUL_W] == '0, "root wider than 15 bits")
	// outside the dead zone the magnitude is never below the radius
	`SDZ_ASSERT_NOW(a_mag_ge_dz, cmd.op == sdz_pkg::OP_MULA,
		mag >= {1'b0, dz_q}, "magnitude below dead zone after test")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-stick radial dead zone and event core
// ----------------------------------------------------------------------------
// Every sample accepted on the input channel is run through a local
// fixed-point model of the dead zone scaling and the per-stick zero history.
// The predicted event is queued, and each transaction on the output channel
// is checked field by field against the oldest entry. Dead zone radii are
// rewritten between phases while nothing is in flight. Both channels idle
// at random, with one burst stretch and one long output stall.
// ----------------------------------------------------------------------------

module tb_top;

	typedef struct {
		logic               tag;
		logic signed [15:0] horiz;
		logic signed [15:0] vert;
		sdz_pkg::action_t   act;
	} stick_event_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               stick;
	logic [7:0]         raw_horizontal;
	logic [7:0]         raw_vertical;
	logic               out_valid;
	logic               out_ready;
	logic               stick_tag;
	logic signed [15:0] conditioned_horizontal;
	logic signed [15:0] conditioned_vertical;
	logic [1:0]         action;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [13:0]        cfg_data;

	// model state: radius and zero history for each stick
	logic [13:0]  zone_radius [2];
	logic         was_zero_prev [2];
	logic         was_zero_older [2];

	stick_event_t expected_events [$];
	int           mismatch_count;
	bit           quiet_mode;
	bit           stall_request;

	stick_radial_deadzone_events_core u_top (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.stick                  (stick),
		.raw_horizontal         (raw_horizontal),
		.raw_vertical           (raw_vertical),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.stick_tag              (stick_tag),
		.conditioned_horizontal (conditioned_horizontal),
		.conditioned_vertical   (conditioned_vertical),
		.action                 (action),
		.cfg_valid              (cfg_valid),
		.cfg_ready              (cfg_ready),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// floor of the square root, built one result bit at a time
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// one axis scaled by (mag - dz) / (1 - dz), rounded half away, saturated
	function automatic logic signed [15:0] scale_axis_q14(input int c,
			input longint unsigned mag, input longint unsigned dz);
		longint unsigned a;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		longint          sq;
		a = 64'((c < 0) ? -c : c);
		a = a * 128;
		num = a * (mag - dz) * 16384;
		den = mag * (16384 - dz);
		q = (num + den / 2) / den;
		if (c < 0) begin
			sq = -longint'(q);
			if (sq < -32768)
				sq = -32768;
		end else begin
			sq = longint'(q);
			if (sq > 32767)
				sq = 32767;
		end
		return sq[15:0];
	endfunction

	// expected event for one sample; advances that stick's zero history
	function automatic stick_event_t predict_event(input logic s,
			input logic [7:0] h, input logic [7:0] v);
		int              cx;
		int              cy;
		longint unsigned m2;
		longint unsigned dz;
		longint unsigned mag;
		logic            cur_zero;
		logic            prev_zero;
		logic            old_zero;
		stick_event_t    ev;
		cx = int'(h);
		cy = int'(v);
		cx = cx - 128;
		cy = cy - 128;
		dz = 64'(zone_radius[s]);
		m2 = 64'(cx * cx + cy * cy);
		ev.tag = s;
		ev.horiz = '0;
		ev.vert = '0;
		if (m2 * 16384 >= dz * dz) begin
			mag = floor_root(m2 * 16384);
			if (mag != 0) begin
				ev.horiz = scale_axis_q14(cx, mag, dz);
				ev.vert = scale_axis_q14(cy, mag, dz);
			end
		end
		cur_zero = (ev.horiz == 0) && (ev.vert == 0);
		prev_zero = was_zero_prev[s];
		old_zero = was_zero_older[s];
		if (cur_zero && prev_zero && !old_zero)
			ev.act = sdz_pkg::ACT_UP;
		else if (!cur_zero && prev_zero && old_zero)
			ev.act = sdz_pkg::ACT_DOWN;
		else
			ev.act = sdz_pkg::ACT_MOVE;
		was_zero_older[s] = prev_zero;
		was_zero_prev[s] = cur_zero;
		return ev;
	endfunction

	// offer one sample, hold it until accepted, then queue its event
	task automatic send_sample(input logic s, input logic [7:0] h, input logic [7:0] v);
		int gaps;
		gaps = 0;
		@(negedge clk);
		while (!quiet_mode && $urandom_range(0, 99) < 11)
			gaps++;
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		in_valid <= 1'b1;
		stick <= s;
		raw_horizontal <= h;
		raw_vertical <= v;
		do
			@(posedge clk);
		while (!in_ready);
		expected_events.push_back(predict_event(s, h, v));
	endtask

	// mix of resting, near-center and full-range samples
	task automatic send_random_sample();
		logic [7:0] h;
		logic [7:0] v;
		int         kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			h = 8'd128;
			v = 8'd128;
		end else if (kind <= 3) begin
			h = 8'($urandom_range(108, 148));
			v = 8'($urandom_range(108, 148));
		end else begin
			h = 8'($urandom_range(0, 255));
			v = 8'($urandom_range(0, 255));
		end
		send_sample(1'($urandom_range(0, 1)), h, v);
	endtask

	// radius write, only while nothing is in flight
	task automatic write_dead_zone(input logic idx, input logic [13:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		zone_radius[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait until every queued event has come out
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
	endtask

	// reset radii: rest, press, move, release and the dead zone edge
	task automatic test_directed_default_zone();
		send_sample(1'b0, 8'd128, 8'd128);
		send_sample(1'b0, 8'd255, 8'd128);
		send_sample(1'b1, 8'd0, 8'd0);
		send_sample(1'b0, 8'd0, 8'd128);
		send_sample(1'b0, 8'd128, 8'd128);
		send_sample(1'b0, 8'd128, 8'd128);
		send_sample(1'b0, 8'd128, 8'd128);
		send_sample(1'b1, 8'd148, 8'd128);
		send_sample(1'b1, 8'd149, 8'd128);
		send_sample(1'b1, 8'd128, 8'd0);
		send_sample(1'b1, 8'd128, 8'd255);
		send_sample(1'b1, 8'd255, 8'd255);
		send_sample(1'b1, 8'd0, 8'd255);
		send_sample(1'b1, 8'd255, 8'd0);
		send_sample(1'b0, 8'd113, 8'd114);
		wait_for_results();
	endtask

	// zero radius at center and tiny offsets, largest radii with saturation
	task automatic test_zone_extremes();
		write_dead_zone(sdz_pkg::CFG_LEFT_DZ, 14'd0);
		write_dead_zone(sdz_pkg::CFG_RIGHT_DZ, 14'h3FFF);
		send_sample(1'b0, 8'd128, 8'd128);
		send_sample(1'b0, 8'd129, 8'd128);
		send_sample(1'b0, 8'd127, 8'd127);
		send_sample(1'b0, 8'd128, 8'd128);
		send_sample(1'b1, 8'd0, 8'd0);
		send_sample(1'b1, 8'd255, 8'd255);
		send_sample(1'b1, 8'd128, 8'd0);
		send_sample(1'b1, 8'd200, 8'd200);
		wait_for_results();
		write_dead_zone(sdz_pkg::CFG_LEFT_DZ, 14'd15360);
		write_dead_zone(sdz_pkg::CFG_RIGHT_DZ, 14'd15360);
		send_sample(1'b0, 8'd0, 8'd128);
		send_sample(1'b0, 8'd255, 8'd255);
		send_sample(1'b1, 8'd10, 8'd20);
		wait_for_results();
	endtask

	// random samples over several radius settings
	task automatic test_random_phases();
		logic [13:0] left_dz;
		logic [13:0] right_dz;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					left_dz = 14'd0;
					right_dz = 14'd15360;
				end
				1: begin
					left_dz = 14'h3FFF;
					right_dz = 14'd0;
				end
				2: begin
					left_dz = sdz_pkg::DZ_RESET;
					right_dz = sdz_pkg::DZ_RESET;
				end
				default: begin
					left_dz = 14'($urandom_range(0, 15360));
					right_dz = 14'($urandom_range(0, 15360));
				end
			endcase
			write_dead_zone(sdz_pkg::CFG_LEFT_DZ, left_dz);
			write_dead_zone(sdz_pkg::CFG_RIGHT_DZ, right_dz);
			repeat (60) send_random_sample();
			wait_for_results();
		end
	endtask

	// receiver holds off for a long stretch while samples keep coming
	task automatic test_output_stall();
		stall_request = 1'b1;
		repeat (24) send_random_sample();
		wait_for_results();
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		quiet_mode = 1'b1;
		repeat (40) send_random_sample();
		wait_for_results();
		quiet_mode = 1'b0;
	endtask

	// receiver: random ready, with a counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet_mode || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	// result checker: each output transaction against the oldest event
	always @(posedge clk) begin
		stick_event_t ev;
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: stick %0d horiz %0d vert %0d action %0d",
						stick_tag, conditioned_horizontal, conditioned_vertical, action);
			end else begin
				ev = expected_events.pop_front();
				if (stick_tag !== ev.tag || conditioned_horizontal !== ev.horiz ||
						conditioned_vertical !== ev.vert || action !== ev.act) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: stick exp %0d got %0d, horiz exp %0d got %0d, ",
							"vert exp %0d got %0d, action exp %0d got %0d"},
							ev.tag, stick_tag, ev.horiz, conditioned_horizontal,
							ev.vert, conditioned_vertical, ev.act, action);
				end
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("stick_radial_deadzone_events_core test failed");
		$finish;
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stick = 1'b0;
		raw_horizontal = 8'd128;
		raw_vertical = 8'd128;
		cfg_valid = 1'b0;
		cfg_index = sdz_pkg::CFG_LEFT_DZ;
		cfg_data = '0;
		quiet_mode = 1'b0;
		stall_request = 1'b0;
		mismatch_count = 0;
		zone_radius[0] = sdz_pkg::DZ_RESET;
		zone_radius[1] = sdz_pkg::DZ_RESET;
		for (int i = 0; i < 2; i++) begin
			was_zero_prev[i] = 1'b1;
			was_zero_older[i] = 1'b1;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_default_zone();
		test_zone_extremes();
		test_random_phases();
		test_output_stall();
		test_back_to_back();

		wait_for_results();
		repeat (70) @(posedge clk);
		if (mismatch_count == 0 && expected_events.size() == 0) begin
			$display("stick_radial_deadzone_events_core test passed");
		end else begin
			$display("stick_radial_deadzone_events_core test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sdz_pkg.sv
rtl/sdz_ctrl.sv
rtl/sdz_datapath.sv
rtl/stick_radial_deadzone_events_core.sv
sim/tb_top.sv
